>>> src/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants
// Widths, constants and the data word that travels down the divider chain.
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned HUE_W     = 15;
    localparam int unsigned SAT_W     = 17;
    localparam int unsigned LSUM_W    = 9;
    localparam int unsigned REM_W     = 25;
    localparam int unsigned QUO_W     = 17;
    localparam int unsigned NUM_CELLS = QUO_W;

    localparam logic [QUO_W-1:0] HUE_FULL_TURN = QUO_W'(23040);
    localparam logic [12:0]      HUE_SECTOR_X2 = 13'd7680;

    typedef struct packed {
        logic              grey;
        logic [LSUM_W-1:0] lsum;
        logic [REM_W-1:0]  s_rem;
        logic [REM_W-1:0]  s_div;
        logic [QUO_W-1:0]  s_quo;
        logic [REM_W-1:0]  h_rem;
        logic [REM_W-1:0]  h_div;
        logic [QUO_W-1:0]  h_quo;
    } div_word_t;

endpackage

>>> src/rhc_prep.sv
// ----------------------------------------------------------------------------
// rhc_prep: pixel front end
// Finds max, min and sector numerator and registers both division setups.
// ----------------------------------------------------------------------------
module rhc_prep (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [rhc_pkg::CH_W-1:0]  red,
    input  logic [rhc_pkg::CH_W-1:0]  green,
    input  logic [rhc_pkg::CH_W-1:0]  blue,
    output logic                      out_valid,
    output rhc_pkg::div_word_t        out_word
);

    logic               valid_reg;
    rhc_pkg::div_word_t word_reg;
    rhc_pkg::div_word_t word_next;

    logic [7:0]  mx;
    logic [7:0]  mn;
    logic [7:0]  delta;
    logic [8:0]  sum;
    logic [7:0]  dval;
    logic [10:0] num;
    logic [10:0] delta_x6;

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        delta = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        dval = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
        delta_x6 = 11'(delta) * 11'd6;
        // Ties on the maximum go to red first, then green.
        if (mx == red)
        begin
            if (green >= blue)
                num = 11'(green - blue);
            else
                num = delta_x6 - 11'(blue - green);
        end
        else if (mx == green)
        begin
            num = 11'({delta, 1'b0}) + 11'(blue) - 11'(red);
        end
        else
        begin
            num = 11'({delta, 2'b00}) + 11'(red) - 11'(green);
        end

        word_next.grey  = (delta == 8'd0);
        word_next.lsum  = sum;
        word_next.s_rem = (25'(delta) << 17) + 25'(dval);
        word_next.s_div = 25'({dval, 1'b0}) << (rhc_pkg::QUO_W - 1);
        word_next.s_quo = '0;
        word_next.h_rem = 25'(num) * 25'(rhc_pkg::HUE_SECTOR_X2) + 25'(delta);
        word_next.h_div = 25'({delta, 1'b0}) << (rhc_pkg::QUO_W - 1);
        word_next.h_quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> src/rhc_cell.sv
// ----------------------------------------------------------------------------
// rhc_cell: one restoring division step
// Settles one quotient bit of both the saturation and the hue division.
// ----------------------------------------------------------------------------
module rhc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  rhc_pkg::div_word_t in_word,
    output logic               out_valid,
    output rhc_pkg::div_word_t out_word
);

    logic               valid_reg;
    rhc_pkg::div_word_t word_reg;
    rhc_pkg::div_word_t word_next;
    logic               s_ge;
    logic               h_ge;

    always_comb
    begin
        s_ge = (in_word.s_rem >= in_word.s_div);
        h_ge = (in_word.h_rem >= in_word.h_div);
        word_next       = in_word;
        word_next.s_rem = s_ge ? in_word.s_rem - in_word.s_div : in_word.s_rem;
        word_next.h_rem = h_ge ? in_word.h_rem - in_word.h_div : in_word.h_rem;
        word_next.s_quo = {in_word.s_quo[rhc_pkg::QUO_W-2:0], s_ge};
        word_next.h_quo = {in_word.h_quo[rhc_pkg::QUO_W-2:0], h_ge};
        // The divisor moves one bit down for the next cell.
        word_next.s_div = in_word.s_div >> 1;
        word_next.h_div = in_word.h_div >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

>>> src/rgb_to_hsl_converter_top.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter_top: RGB to HSL pixel converter
// Pipelined conversion through a chain of restoring division cells.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer condition      Signals
//  pixel     in         start && !busy          red, green, blue
//  result    out        done (one cycle)        hue, saturation, lightness_sum
//
//  One pixel is accepted every clock; busy is always low.
//  The pipeline has one front-end stage, 17 division cells (one
//  quotient bit each) and one output stage.
//  Reset clears the valid bits of every stage; no results are in flight after it.
//  The receiver cannot stall, so the pipeline never holds.
module rgb_to_hsl_converter_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rhc_pkg::CH_W-1:0]    red,
    input  logic [rhc_pkg::CH_W-1:0]    green,
    input  logic [rhc_pkg::CH_W-1:0]    blue,
    output logic                        done,
    output logic [rhc_pkg::HUE_W-1:0]   hue,
    output logic [rhc_pkg::SAT_W-1:0]   saturation,
    output logic [rhc_pkg::LSUM_W-1:0]  lightness_sum
);

    logic               chain_valid [rhc_pkg::NUM_CELLS+1];
    rhc_pkg::div_word_t chain_word  [rhc_pkg::NUM_CELLS+1];

    logic                       done_reg;
    logic [rhc_pkg::HUE_W-1:0]  hue_reg;
    logic [rhc_pkg::HUE_W-1:0]  hue_next;
    logic [rhc_pkg::SAT_W-1:0]  sat_reg;
    logic [rhc_pkg::SAT_W-1:0]  sat_next;
    logic [rhc_pkg::LSUM_W-1:0] lsum_reg;
    rhc_pkg::div_word_t         last_word;
    logic [rhc_pkg::QUO_W-1:0]  hue_wrapped;

    assign busy = 1'b0;

    rhc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (chain_valid[0]),
        .out_word  (chain_word[0])
    );

    for (genvar i = 0; i < rhc_pkg::NUM_CELLS; i++)
    begin : g_cell
        rhc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_word   (chain_word[i]),
            .out_valid (chain_valid[i+1]),
            .out_word  (chain_word[i+1])
        );
    end

    always_comb
    begin
        last_word = chain_word[rhc_pkg::NUM_CELLS];
        // A rounded hue of one full turn wraps back to zero.
        hue_wrapped = (last_word.h_quo >= rhc_pkg::HUE_FULL_TURN)
                    ? last_word.h_quo - rhc_pkg::HUE_FULL_TURN : last_word.h_quo;
        if (last_word.grey)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = hue_wrapped[rhc_pkg::HUE_W-1:0];
            sat_next = last_word.s_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= chain_valid[rhc_pkg::NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[rhc_pkg::NUM_CELLS])
        begin
            hue_reg  <= hue_next;
            sat_reg  <= sat_next;
            lsum_reg <= last_word.lsum;
        end
    end

    assign done          = done_reg;
    assign hue           = hue_reg;
    assign saturation    = sat_reg;
    assign lightness_sum = lsum_reg;

endmodule
